[rtl/imk_pkg.sv]
// ----------------------------------------------------------------------------
// imk_pkg
// Types and constants shared by the iambic keyer unit and its window unit.
// ----------------------------------------------------------------------------
`default_nettype none

package imk_pkg;

    // field widths
    localparam int DOT_W      = 18;
    localparam int DEB_W      = 14;
    localparam int PCT_W      = 7;
    localparam int LEN_W      = 20;
    localparam int CLAMP_W    = LEN_W + 1;
    localparam int PROD_W     = CLAMP_W + PCT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int NOW_W      = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IAMBIC_B     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_OPEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_MARGIN   = 3'd4;

    // register reset values
    localparam logic [DOT_W-1:0] RST_DOT_TIME  = 18'd60000;
    localparam logic             RST_IAMBIC_B  = 1'b1;
    localparam logic [DEB_W-1:0] RST_DEBOUNCE  = 14'd3000;
    localparam logic [PCT_W-1:0] RST_WIN_OPEN  = 7'd0;
    localparam logic [PCT_W-1:0] RST_WIN_MARG  = 7'd0;

    // percent constants
    localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;
    localparam logic [PCT_W-1:0] PCT_FULL_P1   = 7'd101;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DOT  = 2'd1,
        PH_DASH = 2'd2,
        PH_GAP  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        EL_NONE = 2'd0,
        EL_DOT  = 2'd1,
        EL_DASH = 2'd2
    } t_elem;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } t_event;

    // per-tick sequencer
    typedef enum logic [2:0] {
        SQ_IDLE      = 3'd0,
        SQ_PREP      = 3'd1,
        SQ_MUL_SCALE = 3'd2,
        SQ_MUL_OPEN  = 3'd3,
        SQ_MUL_CLOSE = 3'd4,
        SQ_UPD       = 3'd5
    } t_seq;

    // operations of the shared window multiplier
    typedef enum logic [1:0] {
        WOP_SCALE = 2'd0,
        WOP_OPEN  = 2'd1,
        WOP_CLOSE = 2'd2
    } t_win_op;

    typedef struct packed {
        logic    en;
        t_win_op op;
    } t_win_ctrl;

    typedef struct packed {
        logic   key_out;
        logic   dot_level;
        logic   dash_level;
        t_event dot_event;
        logic   dot_squeeze;
        t_event dash_event;
        logic   dash_squeeze;
        t_elem  element_started;
        logic   key_off_event;
    } t_result;

endpackage

`default_nettype wire

[rtl/imk_in_if.sv]
// ----------------------------------------------------------------------------
// imk_in_if
// Tick channel into the keyer: timestamp and raw paddle levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface imk_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_us;
    logic        dot_raw;
    logic        dash_raw;

    modport source (output valid, output now_us, output dot_raw, output dash_raw,
                    input ready);
    modport sink   (input valid, input now_us, input dot_raw, input dash_raw,
                    output ready);
endinterface

`default_nettype wire

[rtl/imk_out_if.sv]
// ----------------------------------------------------------------------------
// imk_out_if
// Result channel out of the keyer: key line, paddle levels and events.
// ----------------------------------------------------------------------------
`default_nettype none

interface imk_out_if;
    logic       valid;
    logic       ready;
    logic       key_out;
    logic       dot_level;
    logic       dash_level;
    logic [1:0] dot_event;
    logic       dot_squeeze;
    logic [1:0] dash_event;
    logic       dash_squeeze;
    logic [1:0] element_started;
    logic       key_off_event;

    modport source (output valid, output key_out, output dot_level, output dash_level,
                    output dot_event, output dot_squeeze, output dash_event,
                    output dash_squeeze, output element_started, output key_off_event,
                    input ready);
    modport sink   (input valid, input key_out, input dot_level, input dash_level,
                    input dot_event, input dot_squeeze, input dash_event,
                    input dash_squeeze, input element_started, input key_off_event,
                    output ready);
endinterface

`default_nettype wire

[rtl/imk_window_unit.sv]
// ----------------------------------------------------------------------------
// imk_window_unit
// Shared multiplier for the memory window test: scales the clamped elapsed
// time by 100, then compares it against open*len and (close+1)*len in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module imk_window_unit
    import imk_pkg::*;
(
    input  logic               i_clk,
    input  t_win_ctrl          i_ctrl,
    input  logic [CLAMP_W-1:0] i_elapsed,
    input  logic [LEN_W-1:0]   i_len,
    input  logic [PCT_W-1:0]   i_open_pct,
    input  logic [PCT_W-1:0]   i_close_p1,
    output logic               o_in_window
);

    logic [CLAMP_W-1:0] mul_a;
    logic [PCT_W-1:0]   mul_b;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  r_scaled;
    logic               r_ge_open;
    logic               r_lt_close;

    // operand selection for the single multiplier
    always_comb begin
        case (i_ctrl.op)
            WOP_SCALE: begin
                mul_a = i_elapsed;
                mul_b = PCT_FULL;
            end
            WOP_OPEN: begin
                mul_a = {1'b0, i_len};
                mul_b = i_open_pct;
            end
            WOP_CLOSE: begin
                mul_a = {1'b0, i_len};
                mul_b = i_close_p1;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = {{PCT_W{1'b0}}, mul_a} * {{CLAMP_W{1'b0}}, mul_b};

    // product capture and window bound compares
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            case (i_ctrl.op)
                WOP_SCALE: r_scaled   <= prod;
                WOP_OPEN:  r_ge_open  <= (r_scaled >= prod);
                WOP_CLOSE: r_lt_close <= (r_scaled < prod);
                default: ;
            endcase
        end
    end

    assign o_in_window = r_ge_open & r_lt_close;

endmodule

`default_nettype wire

[rtl/iambic_morse_keyer_unit.sv]
// ----------------------------------------------------------------------------
// iambic_morse_keyer_unit
// Iambic paddle keyer with debounce and Curtis mode B element memory, run once
// per timestamped tick.
// ----------------------------------------------------------------------------
// each accepted tick runs through the prep, scale, open, close and update steps, and
//   its result is registered when the update step commits; the sequencer steps the
//   shared window multiplier three times per tick and takes a new tick only when idle
// the next tick is taken while a finished result still waits on the output
// reset (synchronous, active low) returns the keyer to idle and the
//   configuration registers to their default values
`default_nettype none

module iambic_morse_keyer_unit
    import imk_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    imk_in_if.sink                i_in,
    imk_out_if.source             o_out
);

    // configuration registers
    logic [DOT_W-1:0] r_dot_time;
    logic             r_iambic_b;
    logic [DEB_W-1:0] r_debounce;
    logic [PCT_W-1:0] r_win_open;
    logic [PCT_W-1:0] r_win_margin;

    // keyer state
    t_phase               r_phase, n_phase;
    logic                 r_key_active, n_key_active;
    t_elem                r_latched, n_latched;
    t_elem                r_last, n_last;
    logic [TIME_BITS-1:0] r_phase_start, n_phase_start;
    logic [LEN_W-1:0]     r_phase_len, n_phase_len;
    logic                 r_dot_held, r_dash_held;
    logic [TIME_BITS-1:0] r_dot_change, r_dash_change;

    // sequencer and per-tick work registers
    t_seq                 r_seq, n_seq;
    t_win_ctrl            win_ctrl;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_dot_raw, r_dash_raw;
    t_event               r_dot_ev, r_dash_ev;
    logic                 r_dot_sq, r_dash_sq;
    logic                 r_done;
    logic [CLAMP_W-1:0]   r_elapsed_c;

    // output register
    t_result r_res;
    logic    r_out_valid;
    logic    out_free;
    logic    commit;

    logic [TIME_BITS+NOW_W-1:0] now_ext;
    logic [TIME_BITS-1:0]       now_t;
    logic [TIME_BITS-1:0]       deb_ext;
    logic [TIME_BITS-1:0]       dot_age, dash_age, elapsed;
    logic                       dot_acc, dash_acc;
    logic                       dot_new, dash_new;
    logic [CLAMP_W-1:0]         len_x2;
    logic [PCT_W-1:0]           margin_sat;
    logic [PCT_W-1:0]           close_p1;
    logic [LEN_W-1:0]           dot_len, dash_len;
    logic                       in_window;
    t_elem                      start_el;
    t_elem                      next_el;
    logic                       key_off;

    // timestamp taken modulo the time width
    assign now_ext = {{TIME_BITS{1'b0}}, i_in.now_us};
    assign now_t   = now_ext[TIME_BITS-1:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_time   <= RST_DOT_TIME;
            r_iambic_b   <= RST_IAMBIC_B;
            r_debounce   <= RST_DEBOUNCE;
            r_win_open   <= RST_WIN_OPEN;
            r_win_margin <= RST_WIN_MARG;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_DOT_TIME:   r_dot_time   <= i_cfg_wr_data[DOT_W-1:0];
                CFG_IAMBIC_B:   r_iambic_b   <= i_cfg_wr_data[0];
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_wr_data[DEB_W-1:0];
                CFG_WIN_OPEN:   r_win_open   <= i_cfg_wr_data[PCT_W-1:0];
                CFG_WIN_MARGIN: r_win_margin <= i_cfg_wr_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_seq == SQ_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;
    assign commit     = (r_seq == SQ_UPD) && out_free;

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SQ_IDLE;
        end else begin
            r_seq <= n_seq;
        end
    end

    // sequencer next state and multiplier steps
    always_comb begin
        n_seq       = r_seq;
        win_ctrl.en = 1'b0;
        win_ctrl.op = WOP_SCALE;
        case (r_seq)
            SQ_IDLE: begin
                if (i_in.valid) begin
                    n_seq = SQ_PREP;
                end
            end
            SQ_PREP: begin
                n_seq = SQ_MUL_SCALE;
            end
            SQ_MUL_SCALE: begin
                win_ctrl.en = 1'b1;
                win_ctrl.op = WOP_SCALE;
                n_seq       = SQ_MUL_OPEN;
            end
            SQ_MUL_OPEN: begin
                win_ctrl.en = 1'b1;
                win_ctrl.op = WOP_OPEN;
                n_seq       = SQ_MUL_CLOSE;
            end
            SQ_MUL_CLOSE: begin
                win_ctrl.en = 1'b1;
                win_ctrl.op = WOP_CLOSE;
                n_seq       = SQ_UPD;
            end
            SQ_UPD: begin
                if (out_free) begin
                    n_seq = SQ_IDLE;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    // tick capture
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_now      <= now_t;
            r_dot_raw  <= i_in.dot_raw;
            r_dash_raw <= i_in.dash_raw;
        end
    end

    // debounce and elapsed time for this tick
    assign deb_ext  = {{(TIME_BITS-DEB_W){1'b0}}, r_debounce};
    assign dot_age  = r_now - r_dot_change;
    assign dash_age = r_now - r_dash_change;
    assign dot_acc  = (r_dot_raw != r_dot_held) && (dot_age >= deb_ext);
    assign dash_acc = (r_dash_raw != r_dash_held) && (dash_age >= deb_ext);
    assign dot_new  = dot_acc ? r_dot_raw : r_dot_held;
    assign dash_new = dash_acc ? r_dash_raw : r_dash_held;
    assign elapsed  = r_now - r_phase_start;
    assign len_x2   = {r_phase_len, 1'b0};

    // paddle state update, dot before dash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_held    <= 1'b0;
            r_dash_held   <= 1'b0;
            r_dot_change  <= '0;
            r_dash_change <= '0;
        end else if (r_seq == SQ_PREP) begin
            r_dot_held  <= dot_new;
            r_dash_held <= dash_new;
            if (dot_acc) begin
                r_dot_change <= r_now;
            end
            if (dash_acc) begin
                r_dash_change <= r_now;
            end
        end
    end

    // events and elapsed clamp for the later steps
    always_ff @(posedge i_clk) begin
        if (r_seq == SQ_PREP) begin
            r_dot_ev  <= dot_acc ? (r_dot_raw ? EV_PRESS : EV_RELEASE) : EV_NONE;
            r_dash_ev <= dash_acc ? (r_dash_raw ? EV_PRESS : EV_RELEASE) : EV_NONE;
            r_dot_sq  <= dot_acc & dot_new & r_dash_held;
            r_dash_sq <= dash_acc & dot_new & dash_new;
            r_done    <= (elapsed >= {{(TIME_BITS-LEN_W){1'b0}}, r_phase_len});
            if (elapsed > {{(TIME_BITS-CLAMP_W){1'b0}}, len_x2}) begin
                r_elapsed_c <= len_x2;
            end else begin
                r_elapsed_c <= elapsed[CLAMP_W-1:0];
            end
        end
    end

    // window bounds
    assign margin_sat = (r_win_margin > PCT_FULL) ? PCT_FULL : r_win_margin;
    assign close_p1   = PCT_FULL_P1 - margin_sat;

    imk_window_unit u_window (
        .i_clk       (i_clk),
        .i_ctrl      (win_ctrl),
        .i_elapsed   (r_elapsed_c),
        .i_len       (r_phase_len),
        .i_open_pct  (r_win_open),
        .i_close_p1  (close_p1),
        .o_in_window (in_window)
    );

    // element lengths
    assign dot_len  = {{(LEN_W-DOT_W){1'b0}}, r_dot_time};
    assign dash_len = dot_len + {dot_len[LEN_W-2:0], 1'b0};

    // keyer phase machine
    always_comb begin
        n_phase       = r_phase;
        n_key_active  = r_key_active;
        n_latched     = r_latched;
        n_last        = r_last;
        n_phase_start = r_phase_start;
        n_phase_len   = r_phase_len;
        start_el      = EL_NONE;
        next_el       = EL_NONE;
        key_off       = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (r_dot_held) begin
                    start_el = EL_DOT;
                end else if (r_dash_held) begin
                    start_el = EL_DASH;
                end
            end
            PH_DOT, PH_DASH: begin
                // mode b memory latch
                if (r_iambic_b && (r_latched == EL_NONE) && in_window) begin
                    if ((r_last == EL_DOT) && r_dash_held) begin
                        n_latched = EL_DASH;
                    end else if ((r_last == EL_DASH) && r_dot_held) begin
                        n_latched = EL_DOT;
                    end
                end
                if (r_done) begin
                    n_key_active  = 1'b0;
                    key_off       = 1'b1;
                    n_phase       = PH_GAP;
                    n_phase_start = r_now;
                    n_phase_len   = dot_len;
                end
            end
            default: begin
                if (r_done) begin
                    if (r_iambic_b) begin
                        if (r_latched != EL_NONE) begin
                            next_el   = r_latched;
                            n_latched = EL_NONE;
                        end else if (r_dot_held && !r_dash_held) begin
                            next_el = EL_DOT;
                        end else if (r_dash_held && !r_dot_held) begin
                            next_el = EL_DASH;
                        end else if (r_dot_held && r_dash_held) begin
                            next_el = (r_last == EL_DOT) ? EL_DASH : EL_DOT;
                        end
                    end
                    if (next_el != EL_NONE) begin
                        start_el = next_el;
                    end else begin
                        n_phase      = PH_IDLE;
                        n_last       = EL_NONE;
                        n_key_active = 1'b0;
                    end
                end
            end
        endcase
        // element start
        if (start_el != EL_NONE) begin
            n_last        = start_el;
            n_phase_start = r_now;
            n_key_active  = 1'b1;
            if (start_el == EL_DOT) begin
                n_phase     = PH_DOT;
                n_phase_len = dot_len;
            end else begin
                n_phase     = PH_DASH;
                n_phase_len = dash_len;
            end
        end
    end

    // keyer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_key_active  <= 1'b0;
            r_latched     <= EL_NONE;
            r_last        <= EL_NONE;
            r_phase_start <= '0;
            r_phase_len   <= '0;
        end else if (commit) begin
            r_phase       <= n_phase;
            r_key_active  <= n_key_active;
            r_latched     <= n_latched;
            r_last        <= n_last;
            r_phase_start <= n_phase_start;
            r_phase_len   <= n_phase_len;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_res.key_out         <= n_key_active;
            r_res.dot_level       <= r_dot_held;
            r_res.dash_level      <= r_dash_held;
            r_res.dot_event       <= r_dot_ev;
            r_res.dot_squeeze     <= r_dot_sq;
            r_res.dash_event      <= r_dash_ev;
            r_res.dash_squeeze    <= r_dash_sq;
            r_res.element_started <= start_el;
            r_res.key_off_event   <= key_off;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.key_out         = r_res.key_out;
    assign o_out.dot_level       = r_res.dot_level;
    assign o_out.dash_level      = r_res.dash_level;
    assign o_out.dot_event       = r_res.dot_event;
    assign o_out.dot_squeeze     = r_res.dot_squeeze;
    assign o_out.dash_event      = r_res.dash_event;
    assign o_out.dash_squeeze    = r_res.dash_squeeze;
    assign o_out.element_started = r_res.element_started;
    assign o_out.key_off_event   = r_res.key_off_event;

    // key line follows the sounding phases
    a_key_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_active == ((r_phase == PH_DOT) || (r_phase == PH_DASH)))
        else $error("key line disagrees with keyer phase");

    // a started element keys the transmitter in the same transaction
    a_start_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.element_started != EL_NONE)) |-> r_res.key_out)
        else $error("element started without key down");

    // an element end releases the key
    a_keyoff_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.key_off_event) |-> !r_res.key_out)
        else $error("key off event with key still down");

    // an accepted tick enters the preparation step next
    a_tick_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_seq == SQ_PREP))
        else $error("accepted tick did not start the sequencer");

endmodule

`default_nettype wire
